// ===== hdl/lfu_pkg.sv =====
// lfu_pkg: shared constants and types of the lfu replacement table
// command and status codes, sequencer states, scan and write control groups
// no dependencies
`default_nettype none

package lfu_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int CMD_W   = 3;
    localparam int ID_W    = 8;
    localparam int CNT_W   = 16;
    localparam int STAMP_W = 16;
    localparam int STAT_W  = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOUCH        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_LEAST    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY_OLDEST = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY_COUNT  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_REFUSED   = 3'd4;

    localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;
    localparam logic [STAMP_W-1:0] STAMP_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // summary flags of one scan pass
    typedef struct packed {
        logic found;       // id matched a valid slot
        logic free_found;  // some slot is free
        logic any;         // table holds at least one entry
        logic best_any;    // a minimum candidate exists
    } t_scan_flags;

    // write controls toward the slot store
    typedef struct packed {
        logic set_valid;
        logic clr_valid;
        logic we_all;
        logic we_cnt;
    } t_wr_ctl;

endpackage

`default_nettype wire

// ===== hdl/lfu_store.sv =====
// lfu_store: slot storage, valid flops plus id, count and stamp memories
// one registered read port, one write port
// depends on lfu_pkg
`default_nettype none

module lfu_store #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_rd_addr,
    output logic                               o_rd_valid,
    output logic [lfu_pkg::ID_W-1:0]           o_rd_id,
    output logic [lfu_pkg::CNT_W-1:0]          o_rd_cnt,
    output logic [lfu_pkg::STAMP_W-1:0]        o_rd_stamp,
    input  wire lfu_pkg::t_wr_ctl              i_wr_ctl,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_wr_addr,
    input  wire logic [lfu_pkg::ID_W-1:0]      i_wr_id,
    input  wire logic [lfu_pkg::CNT_W-1:0]     i_wr_cnt,
    input  wire logic [lfu_pkg::STAMP_W-1:0]   i_wr_stamp
);

    logic [CAPACITY-1:0]              r_slot_valid;
    logic [lfu_pkg::ID_W-1:0]         r_mem_id    [CAPACITY];
    logic [lfu_pkg::CNT_W-1:0]        r_mem_cnt   [CAPACITY];
    logic [lfu_pkg::STAMP_W-1:0]      r_mem_stamp [CAPACITY];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (i_wr_ctl.set_valid) begin
            r_slot_valid[i_wr_addr] <= 1'b1;
        end else if (i_wr_ctl.clr_valid) begin
            r_slot_valid[i_wr_addr] <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.we_all) begin
            r_mem_id[i_wr_addr]    <= i_wr_id;
            r_mem_stamp[i_wr_addr] <= i_wr_stamp;
        end
        if (i_wr_ctl.we_all || i_wr_ctl.we_cnt) begin
            r_mem_cnt[i_wr_addr] <= i_wr_cnt;
        end
        o_rd_id    <= r_mem_id[i_rd_addr];
        o_rd_cnt   <= r_mem_cnt[i_rd_addr];
        o_rd_stamp <= r_mem_stamp[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rd_valid <= 1'b0;
        end else begin
            o_rd_valid <= r_slot_valid[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lfu_scan.sv =====
// lfu_scan: compare unit reused once per slot, keeps the running
// id match, first free slot, largest stamp and least entry of a pass
// depends on lfu_pkg
`default_nettype none

module lfu_scan #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic                          i_step,
    input  wire logic [lfu_pkg::ID_W-1:0]      i_key,
    input  wire logic                          i_by_count,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_idx,
    input  wire logic                          i_valid,
    input  wire logic [lfu_pkg::ID_W-1:0]      i_id,
    input  wire logic [lfu_pkg::CNT_W-1:0]     i_cnt,
    input  wire logic [lfu_pkg::STAMP_W-1:0]   i_stamp,
    output lfu_pkg::t_scan_flags               o_flags,
    output logic [$clog2(CAPACITY)-1:0]        o_found_idx,
    output logic [lfu_pkg::CNT_W-1:0]          o_found_cnt,
    output logic [$clog2(CAPACITY)-1:0]        o_free_idx,
    output logic [lfu_pkg::STAMP_W-1:0]        o_max_stamp,
    output logic [$clog2(CAPACITY)-1:0]        o_best_idx,
    output logic [lfu_pkg::ID_W-1:0]           o_best_id,
    output logic [lfu_pkg::CNT_W-1:0]          o_best_cnt
);

    localparam int IDX_W = $clog2(CAPACITY);

    lfu_pkg::t_scan_flags           r_flags;
    logic [IDX_W-1:0]               r_found_idx;
    logic [lfu_pkg::CNT_W-1:0]      r_found_cnt;
    logic [IDX_W-1:0]               r_free_idx;
    logic [lfu_pkg::STAMP_W-1:0]    r_max_stamp;
    logic [IDX_W-1:0]               r_best_idx;
    logic [lfu_pkg::ID_W-1:0]       r_best_id;
    logic [lfu_pkg::CNT_W-1:0]      r_best_cnt;
    logic [lfu_pkg::STAMP_W-1:0]    r_best_stamp;

    logic hit;
    logic take_free;
    logic take_max;
    logic better;
    logic take_best;

    always_comb begin
        hit       = i_valid && (i_id == i_key) && !r_flags.found;
        take_free = !i_valid && !r_flags.free_found;
        take_max  = i_valid && (!r_flags.any || (i_stamp > r_max_stamp));
        // count first when popping, stamp breaks ties
        if (i_by_count && (i_cnt != r_best_cnt)) begin
            better = i_cnt < r_best_cnt;
        end else begin
            better = i_stamp < r_best_stamp;
        end
        take_best = i_valid && (!r_flags.best_any || better);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
        end else if (i_step) begin
            if (hit)       r_flags.found      <= 1'b1;
            if (take_free) r_flags.free_found <= 1'b1;
            if (i_valid)   r_flags.any        <= 1'b1;
            if (take_best) r_flags.best_any   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (hit) begin
                r_found_idx <= i_idx;
                r_found_cnt <= i_cnt;
            end
            if (take_free) begin
                r_free_idx <= i_idx;
            end
            if (take_max) begin
                r_max_stamp <= i_stamp;
            end
            if (take_best) begin
                r_best_idx   <= i_idx;
                r_best_id    <= i_id;
                r_best_cnt   <= i_cnt;
                r_best_stamp <= i_stamp;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_found_idx = r_found_idx;
    assign o_found_cnt = r_found_cnt;
    assign o_free_idx  = r_free_idx;
    assign o_max_stamp = r_max_stamp;
    assign o_best_idx  = r_best_idx;
    assign o_best_id   = r_best_id;
    assign o_best_cnt  = r_best_cnt;

endmodule

`default_nettype wire

// ===== hdl/lfu_replacement_table_core.sv =====
// lfu_replacement_table_core: least-frequently-used table with oldest-first tie break
// sequencer that walks every slot through lfu_scan, then commits into lfu_store
// depends on lfu_pkg, lfu_store, lfu_scan
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------------
//  command   | i_cmd, i_entry_id                       | start high and busy low
//  result    | o_status, o_result_id, o_result_count   | o_done high for one cycle
//
//  every command walks one slot per cycle through the single memory read port, then a
//  drain state empties the read register, then a commit state writes the store and
//  registers the result word
//  busy stays high through scan, drain and commit; a new word is taken in the strobe cycle
//  reset (synchronous, active low) clears the valid bits and the sequencer at once
//  the receiver cannot stall: o_done is shown for exactly one cycle
`default_nettype none

module lfu_replacement_table_core #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lfu_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [lfu_pkg::ID_W-1:0]      i_entry_id,
    output logic                               o_done,
    output logic [lfu_pkg::STAT_W-1:0]         o_status,
    output logic [lfu_pkg::ID_W-1:0]           o_result_id,
    output logic [lfu_pkg::CNT_W-1:0]          o_result_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // sequencer
    lfu_pkg::t_state                r_state;
    lfu_pkg::t_state                n_state;
    logic [IDX_W-1:0]               r_addr;
    logic [IDX_W-1:0]               n_addr;
    logic [lfu_pkg::CMD_W-1:0]      r_cmd;
    logic [lfu_pkg::ID_W-1:0]       r_key;
    logic                           r_rd_en;    // read data valid for slot r_rd_idx
    logic [IDX_W-1:0]               r_rd_idx;

    // sequencer outputs
    logic accept;
    logic issue_rd;
    logic commit;

    // store read side
    logic                           rd_valid;
    logic [lfu_pkg::ID_W-1:0]       rd_id;
    logic [lfu_pkg::CNT_W-1:0]      rd_cnt;
    logic [lfu_pkg::STAMP_W-1:0]    rd_stamp;

    // scan results
    lfu_pkg::t_scan_flags           flags;
    logic [IDX_W-1:0]               found_idx;
    logic [lfu_pkg::CNT_W-1:0]      found_cnt;
    logic [IDX_W-1:0]               free_idx;
    logic [lfu_pkg::STAMP_W-1:0]    max_stamp;
    logic [IDX_W-1:0]               best_idx;
    logic [lfu_pkg::ID_W-1:0]       best_id;
    logic [lfu_pkg::CNT_W-1:0]      best_cnt;

    // commit decision
    lfu_pkg::t_wr_ctl               wr_ctl;
    logic [IDX_W-1:0]               wr_addr;
    logic [lfu_pkg::CNT_W-1:0]      wr_cnt;
    logic [lfu_pkg::STAMP_W-1:0]    wr_stamp;
    logic [lfu_pkg::CNT_W-1:0]      touch_cnt;
    logic [lfu_pkg::STAT_W-1:0]     res_status;
    logic [lfu_pkg::ID_W-1:0]       res_id;
    logic [lfu_pkg::CNT_W-1:0]      res_cnt;

    // result word
    logic                           r_done;
    logic [lfu_pkg::STAT_W-1:0]     r_status;
    logic [lfu_pkg::ID_W-1:0]       r_result_id;
    logic [lfu_pkg::CNT_W-1:0]      r_result_count;

    assign busy = (r_state != lfu_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                n_addr = '0;
                if (start) begin
                    n_state = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_state = lfu_pkg::ST_DRAIN;
                end
            end
            lfu_pkg::ST_DRAIN: begin
                n_state = lfu_pkg::ST_COMMIT;
            end
            lfu_pkg::ST_COMMIT: begin
                n_state = lfu_pkg::ST_IDLE;
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        accept   = 1'b0;
        issue_rd = 1'b0;
        commit   = 1'b0;
        case (r_state)
            lfu_pkg::ST_IDLE:   accept   = start;
            lfu_pkg::ST_SCAN:   issue_rd = 1'b1;
            lfu_pkg::ST_DRAIN:  ;
            lfu_pkg::ST_COMMIT: commit   = 1'b1;
            default:            ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
            r_rd_en <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_en <= issue_rd;
            r_done  <= commit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rd_idx <= r_addr;
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_entry_id;
        end
        if (commit) begin
            r_status       <= res_status;
            r_result_id    <= res_id;
            r_result_count <= res_cnt;
        end
    end

    lfu_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_addr),
        .o_rd_valid (rd_valid),
        .o_rd_id    (rd_id),
        .o_rd_cnt   (rd_cnt),
        .o_rd_stamp (rd_stamp),
        .i_wr_ctl   (wr_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_id    (r_key),
        .i_wr_cnt   (wr_cnt),
        .i_wr_stamp (wr_stamp)
    );

    // one slot per cycle through the shared compare unit
    lfu_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (accept),
        .i_step      (r_rd_en),
        .i_key       (r_key),
        .i_by_count  (r_cmd == lfu_pkg::CMD_POP_LEAST),
        .i_idx       (r_rd_idx),
        .i_valid     (rd_valid),
        .i_id        (rd_id),
        .i_cnt       (rd_cnt),
        .i_stamp     (rd_stamp),
        .o_flags     (flags),
        .o_found_idx (found_idx),
        .o_found_cnt (found_cnt),
        .o_free_idx  (free_idx),
        .o_max_stamp (max_stamp),
        .o_best_idx  (best_idx),
        .o_best_id   (best_id),
        .o_best_cnt  (best_cnt)
    );

    // touch saturates at the count ceiling
    assign touch_cnt = (found_cnt == lfu_pkg::CNT_MAX) ? found_cnt : found_cnt + 1'b1;

    // commit decision, only acted on in the commit cycle
    always_comb begin
        wr_ctl     = '0;
        wr_addr    = found_idx;
        wr_cnt     = touch_cnt;
        wr_stamp   = flags.any ? max_stamp + 1'b1 : '0;
        res_status = lfu_pkg::STAT_OK;
        res_id     = r_key;
        res_cnt    = '0;
        case (r_cmd)
            lfu_pkg::CMD_INSERT: begin
                wr_addr = free_idx;
                wr_cnt  = lfu_pkg::CNT_W'(1);
                // duplicate first, then fullness, then stamp exhaustion
                if (flags.found) begin
                    res_status = lfu_pkg::STAT_REFUSED;
                end else if (!flags.free_found) begin
                    res_status = lfu_pkg::STAT_FULL;
                end else if (flags.any && (max_stamp == lfu_pkg::STAMP_MAX)) begin
                    res_status = lfu_pkg::STAT_REFUSED;
                end else begin
                    wr_ctl.set_valid = commit;
                    wr_ctl.we_all    = commit;
                    res_cnt          = lfu_pkg::CNT_W'(1);
                end
            end
            lfu_pkg::CMD_TOUCH: begin
                if (!flags.found) begin
                    res_status = lfu_pkg::STAT_NOT_FOUND;
                end else begin
                    wr_ctl.we_cnt = commit;
                    res_cnt       = touch_cnt;
                end
            end
            lfu_pkg::CMD_POP_LEAST, lfu_pkg::CMD_QUERY_OLDEST: begin
                wr_addr = best_idx;
                if (!flags.best_any) begin
                    res_status = lfu_pkg::STAT_EMPTY;
                end else begin
                    res_id  = best_id;
                    res_cnt = best_cnt;
                    wr_ctl.clr_valid = commit && (r_cmd == lfu_pkg::CMD_POP_LEAST);
                end
            end
            lfu_pkg::CMD_REMOVE: begin
                if (!flags.found) begin
                    res_status = lfu_pkg::STAT_NOT_FOUND;
                end else begin
                    wr_ctl.clr_valid = commit;
                end
            end
            lfu_pkg::CMD_QUERY_COUNT: begin
                if (!flags.found) begin
                    res_status = lfu_pkg::STAT_NOT_FOUND;
                end else begin
                    res_cnt = found_cnt;
                end
            end
            default: begin
                // unknown command leaves the table alone
                res_status = lfu_pkg::STAT_REFUSED;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_id    = r_result_id;
    assign o_result_count = r_result_count;

    // a result word comes only out of a commit cycle
    a_done_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == lfu_pkg::ST_COMMIT))
        else $error("result strobe without commit");

    // an accepted command starts the slot walk at slot zero
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == lfu_pkg::ST_SCAN) && (r_addr == '0))
        else $error("accepted command did not start a scan");

    // a successful insert always reports a count of one
    a_insert_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_cmd == lfu_pkg::CMD_INSERT) && (o_status == lfu_pkg::STAT_OK))
        |-> (o_result_count == lfu_pkg::CNT_W'(1)))
        else $error("insert returned a count other than one");

    // the store is never written outside the commit cycle
    a_write_only_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ctl != '0) |-> (r_state == lfu_pkg::ST_COMMIT))
        else $error("store written outside commit");

endmodule

`default_nettype wire
